[src/oer_pkg.sv]
// ----------------------------------------------------------------------------
// oer_pkg: shared definitions for the overwrite event ring
// Field widths, parameter defaults, operation codes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package oer_pkg;

  localparam int DEF_RING_DEPTH  = 512;
  localparam int DEF_PEEK_BATCH  = 8;
  localparam int DEF_EVENT_WIDTH = 64;

  localparam int DATA_W = 64;
  localparam int KIND_W = 2;
  localparam int CNT_W  = 4;
  localparam int PEND_W = 10;
  localparam int DROP_W = 32;

  localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PEEK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  typedef struct packed {
    logic single_op;
    logic peek_load;
    logic peek_issue;
  } cmd_t;

  typedef struct packed {
    logic peek_run;
    logic peek_last;
  } stat_t;

endpackage

`default_nettype wire

[src/oer_ctrl.sv]
// ----------------------------------------------------------------------------
// oer_ctrl: transaction sequencer
// Accepts transactions, runs multi-result peeks and drives busy.
// ----------------------------------------------------------------------------
`default_nettype none

module oer_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [oer_pkg::KIND_W-1:0] kind,
  input  wire oer_pkg::stat_t            stat,
  output oer_pkg::cmd_t                  cmd,
  output logic                           busy
);

  typedef enum logic {
    ST_IDLE,
    ST_PEEK
  } state_t;

  state_t state;
  logic   accept;
  logic   go_peek;

  assign accept  = start && (state == ST_IDLE);
  assign go_peek = accept && (kind == oer_pkg::KIND_PEEK) && stat.peek_run;

  always_comb begin
    cmd.single_op  = accept && !go_peek;
    cmd.peek_load  = go_peek;
    cmd.peek_issue = (state == ST_PEEK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (go_peek) begin
            state <= ST_PEEK;
            busy  <= 1'b1;
          end
        end
        ST_PEEK: begin
          if (stat.peek_last) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/oer_datapath.sv]
// ----------------------------------------------------------------------------
// oer_datapath: ring storage, pointers and result registers
// Holds the event memory, read and write pointers, the drop counter and
// the registered result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module oer_datapath #(
  parameter int RING_DEPTH  = oer_pkg::DEF_RING_DEPTH,
  parameter int PEEK_BATCH  = oer_pkg::DEF_PEEK_BATCH,
  parameter int EVENT_WIDTH = oer_pkg::DEF_EVENT_WIDTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire oer_pkg::cmd_t               cmd,
  input  wire logic [oer_pkg::KIND_W-1:0]  kind,
  input  wire logic [oer_pkg::DATA_W-1:0]  event_data,
  input  wire logic [oer_pkg::CNT_W-1:0]   count,
  output oer_pkg::stat_t                   stat,
  output logic                             strobe,
  output logic [oer_pkg::DATA_W-1:0]       event_data_res,
  output logic                             last,
  output logic                             empty_res,
  output logic                             overwrote,
  output logic [oer_pkg::CNT_W-1:0]        released,
  output logic [oer_pkg::PEND_W-1:0]       pending,
  output logic [oer_pkg::DROP_W-1:0]       dropped_total
);

  localparam int ADDR_W  = $clog2(RING_DEPTH);
  localparam int PTR_W   = ADDR_W + 1;
  localparam int SPAN    = 2 * RING_DEPTH;
  localparam int BATCH_W = $clog2(PEEK_BATCH + 1);
  localparam int MAX_A   = (PTR_W > oer_pkg::CNT_W) ? PTR_W : oer_pkg::CNT_W;
  localparam int MAX_B   = (MAX_A > BATCH_W) ? MAX_A : BATCH_W;
  localparam int SUM_W   = MAX_B + 1;
  localparam int CNT_W   = oer_pkg::CNT_W;

  logic [EVENT_WIDTH-1:0]    mem [RING_DEPTH];
  logic [EVENT_WIDTH-1:0]    mem_q;

  logic [PTR_W-1:0]          wr_ptr;
  logic [PTR_W-1:0]          rd_ptr;
  logic [oer_pkg::DROP_W-1:0] drop_cnt;
  logic [CNT_W-1:0]          peek_len;
  logic [CNT_W-1:0]          peek_idx;

  logic                      res_sel;

  logic [PTR_W-1:0]          pend;
  logic                      full;
  logic [SUM_W-1:0]          cnt_w;
  logic [SUM_W-1:0]          cnt_clamp;
  logic [SUM_W-1:0]          pend_w;
  logic [SUM_W-1:0]          n_peek;
  logic [SUM_W-1:0]          n_rel;
  logic [ADDR_W-1:0]         rd_addr;
  logic [ADDR_W-1:0]         wr_addr;
  logic                      do_push;

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p,
                                               input logic [SUM_W-1:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + n;
    if (s >= SUM_W'(SPAN)) begin
      s = s - SUM_W'(SPAN);
    end
    return PTR_W'(s);
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    q = (p >= PTR_W'(RING_DEPTH)) ? (p - PTR_W'(RING_DEPTH)) : p;
    return ADDR_W'(q);
  endfunction

  always_comb begin
    if (wr_ptr >= rd_ptr) begin
      pend = wr_ptr - rd_ptr;
    end else begin
      pend = PTR_W'(SUM_W'(wr_ptr) + SUM_W'(SPAN) - SUM_W'(rd_ptr));
    end
    full      = (pend >= PTR_W'(RING_DEPTH));
    pend_w    = SUM_W'(pend);
    cnt_w     = SUM_W'(count);
    cnt_clamp = (cnt_w > SUM_W'(PEEK_BATCH)) ? SUM_W'(PEEK_BATCH) : cnt_w;
    n_peek    = (cnt_clamp < pend_w) ? cnt_clamp : pend_w;
    n_rel     = (cnt_w < pend_w) ? cnt_w : pend_w;
    rd_addr   = ptr_slot(ptr_adv(rd_ptr, SUM_W'(peek_idx)));
    wr_addr   = ptr_slot(wr_ptr);
    do_push   = cmd.single_op && (kind == oer_pkg::KIND_PUSH);
  end

  always_comb begin
    stat.peek_run  = (pend != '0) && (count != '0);
    stat.peek_last = (peek_idx == (peek_len - CNT_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_addr] <= event_data[EVENT_WIDTH-1:0];
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      drop_cnt <= '0;
      peek_idx <= '0;
      strobe   <= 1'b0;
    end else begin
      strobe <= cmd.single_op || cmd.peek_issue;
      if (do_push) begin
        wr_ptr <= ptr_adv(wr_ptr, SUM_W'(1));
        if (full) begin
          rd_ptr   <= ptr_adv(rd_ptr, SUM_W'(1));
          drop_cnt <= drop_cnt + oer_pkg::DROP_W'(1);
        end
      end
      if (cmd.single_op && (kind == oer_pkg::KIND_RELEASE)) begin
        rd_ptr <= ptr_adv(rd_ptr, n_rel);
      end
      if (cmd.peek_load) begin
        peek_idx <= '0;
      end else if (cmd.peek_issue) begin
        peek_idx <= peek_idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.peek_load) begin
      peek_len <= CNT_W'(n_peek);
    end
    if (cmd.single_op) begin
      res_sel   <= 1'b0;
      last      <= 1'b1;
      empty_res <= (kind == oer_pkg::KIND_PEEK) && (pend == '0);
      overwrote <= (kind == oer_pkg::KIND_PUSH) && full;
      released  <= (kind == oer_pkg::KIND_RELEASE) ? CNT_W'(n_rel) : '0;
    end else if (cmd.peek_issue) begin
      res_sel   <= 1'b1;
      last      <= stat.peek_last;
      empty_res <= 1'b0;
      overwrote <= 1'b0;
      released  <= '0;
    end
  end

  assign event_data_res = res_sel ? oer_pkg::DATA_W'(mem_q) : '0;
  assign pending        = oer_pkg::PEND_W'(pend);
  assign dropped_total  = drop_cnt;

endmodule

`default_nettype wire

[src/overwrite_event_ring.sv]
// ----------------------------------------------------------------------------
// overwrite_event_ring: event ring that overwrites the oldest entry
// Push, peek and release transactions on a fixed-depth ring of event words.
//
// Channel   Direction  Handshake              Fields
// command   in         start && !busy         kind, event_data, count
// result    out        strobe (one cycle)     event_data_res, last, empty_res,
//                                             overwrote, released, pending,
//                                             dropped_total
//
// A push, release, unused kind or a peek that returns no event keeps busy low
// and its result shows on the following cycle. A peek returning n events
// holds busy through its n reads, one memory read a cycle through the single
// read port; each result follows in the cycle after its read.
// Reset clears pointers, drop count and control; the memory is not cleared.
// The result side cannot stall; each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module overwrite_event_ring #(
  parameter int RING_DEPTH  = oer_pkg::DEF_RING_DEPTH,
  parameter int PEEK_BATCH  = oer_pkg::DEF_PEEK_BATCH,
  parameter int EVENT_WIDTH = oer_pkg::DEF_EVENT_WIDTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [oer_pkg::KIND_W-1:0]  kind,
  input  wire logic [oer_pkg::DATA_W-1:0]  event_data,
  input  wire logic [oer_pkg::CNT_W-1:0]   count,
  output logic                             strobe,
  output logic [oer_pkg::DATA_W-1:0]       event_data_res,
  output logic                             last,
  output logic                             empty_res,
  output logic                             overwrote,
  output logic [oer_pkg::CNT_W-1:0]        released,
  output logic [oer_pkg::PEND_W-1:0]       pending,
  output logic [oer_pkg::DROP_W-1:0]       dropped_total
);

  oer_pkg::cmd_t  cmd;
  oer_pkg::stat_t stat;

  oer_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  oer_datapath #(
    .RING_DEPTH  (RING_DEPTH),
    .PEEK_BATCH  (PEEK_BATCH),
    .EVENT_WIDTH (EVENT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .kind           (kind),
    .event_data     (event_data),
    .count          (count),
    .stat           (stat),
    .strobe         (strobe),
    .event_data_res (event_data_res),
    .last           (last),
    .empty_res      (empty_res),
    .overwrote      (overwrote),
    .released       (released),
    .pending        (pending),
    .dropped_total  (dropped_total)
  );

  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  a_busy_ends_last: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> (strobe && last))
    else $error("peek ended without a final result");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (strobe && empty_res) |-> (last && (pending == '0) && (event_data_res == '0)))
    else $error("empty result inconsistent");

  a_overwrite_full: assert property (@(posedge clk) disable iff (rst)
    (strobe && overwrote) |-> (pending == oer_pkg::PEND_W'(RING_DEPTH)))
    else $error("overwrite reported with ring not full");

endmodule

`default_nettype wire
